// ----- hw/rtl/aabb_frustum_cull_core_assert.svh -----
// Assertion macros for the frustum cull core.
// All of them sample on clock and are disabled while reset is high.
`ifndef AABB_FRUSTUM_CULL_CORE_ASSERT_SVH
`define AABB_FRUSTUM_CULL_CORE_ASSERT_SVH

// Same-cycle implication.
`define AAFC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define AAFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/aafc_pkg.sv -----
// ----------------------------------------------------------------------------
// aafc_pkg
// Shared types, constants and fixed-point helpers of the frustum cull core.
// ----------------------------------------------------------------------------
package aafc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int TABLE_DEPTH = 36;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int PLANE_BASE  = 12;
   localparam int MUL_W       = WORD_WIDTH + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = WORD_WIDTH + 2;
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = 32;
   localparam int DIST_W      = 31;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TEST  = 1'b1;

   localparam logic CSR_NEAR = 1'b0;
   localparam logic CSR_FAR  = 1'b1;

   localparam logic [DIST_W-1:0] NEAR_RESET = 31'd6554;
   localparam logic [DIST_W-1:0] FAR_RESET  = 31'd65536000;
   localparam logic [DIST_W-1:0] DIST_MAX   = 31'h7FFF_FFFF;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XFORM,
      ST_PLANE,
      ST_DIST,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_stat_type;

   // floor(p / 2^FRAC_BITS), saturated to a signed word
   function automatic word_type qsat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(signed'(32'sh7FFF_FFFF));
      lo = PROD_W'(signed'(32'sh8000_0000));
      s  = p >>> FRAC_BITS;
      if (s > hi)      return word_type'(32'sh7FFF_FFFF);
      else if (s < lo) return word_type'(32'sh8000_0000);
      else             return word_type'(s[WORD_WIDTH-1:0]);
   endfunction

   function automatic word_type sat_acc(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(signed'(32'sh7FFF_FFFF));
      lo = ACC_W'(signed'(32'sh8000_0000));
      if (v > hi)      return word_type'(32'sh7FFF_FFFF);
      else if (v < lo) return word_type'(32'sh8000_0000);
      else             return word_type'(v[WORD_WIDTH-1:0]);
   endfunction

endpackage

// ----- hw/rtl/aafc_ram.sv -----
// ----------------------------------------------------------------------------
// aafc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aafc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/aafc_mul.sv -----
// ----------------------------------------------------------------------------
// aafc_mul
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
module aafc_mul (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [aafc_pkg::MUL_W-1:0]    op_a,
   input  logic signed [aafc_pkg::MUL_W-1:0]    op_b,
   output logic signed [aafc_pkg::PROD_W-1:0]   prod
);

   logic signed [aafc_pkg::PROD_W-1:0] prod_ff;
   logic signed [aafc_pkg::PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/aafc_sqrt.sv -----
// ----------------------------------------------------------------------------
// aafc_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module aafc_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  aafc_pkg::sqrt_ctl_type  ctl,
   output aafc_pkg::sqrt_stat_type stat
);

   localparam int RW = aafc_pkg::RAD_W;

   logic [RW-1:0] v_ff, v_in;
   logic [RW-1:0] r_ff, r_in;
   logic [RW-1:0] bit_ff, bit_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW:0]   trial;

   assign trial = {1'b0, r_ff} + {1'b0, bit_ff};

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         v_in    = ctl.radicand;
         r_in    = '0;
         bit_in  = RW'(1) << (RW - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[RW-1:0];
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.root = r_ff[aafc_pkg::ROOT_W-1:0];

endmodule

// ----- hw/rtl/aabb_frustum_cull_core.sv -----
// Sequence: a box test runs 96 transform words, then 24 plane words, then two distance
// passes of three squaring steps, each followed by a square root pass, and a finish step.
// Requests, coefficient writes included, are taken only while idle; a stalled result
// holds the next box in finish.
// Reset: synchronous, clears the coefficient valid bits (table reads as zero)
// and loads near 6554 and far 65536000.
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core
// Box versus view frustum test driven by a small sequencer around one
// multiplier, one accumulator and one square root unit.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [5:0]                            req_coef_index,
   input  logic signed [31:0]                    req_coef_value,
   input  logic signed [31:0]                    req_box_min_x,
   input  logic signed [31:0]                    req_box_min_y,
   input  logic signed [31:0]                    req_box_min_z,
   input  logic signed [31:0]                    req_box_max_x,
   input  logic signed [31:0]                    req_box_max_y,
   input  logic signed [31:0]                    req_box_max_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_visible,
   output logic signed [31:0]                    rsp_min_plane_distance,
   output logic [30:0]                           rsp_eye_distance,
   output logic [30:0]                           rsp_frustum_mid_distance,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_index,
   input  logic [30:0]                           csr_write_data
);

`include "aabb_frustum_cull_core_assert.svh"

   localparam int AW = aafc_pkg::ADDR_W;
   localparam int MW = aafc_pkg::MUL_W;
   localparam int CW = aafc_pkg::ACC_W;

   aafc_pkg::state_type state_ff, state_in;

   logic [2:0]  grp_ff, grp_in;     // corner, plane or distance pass
   logic [1:0]  row_ff, row_in;     // view row or distance axis
   logic [1:0]  word_ff, word_in;
   logic [1:0]  ph_ff, ph_in;

   aafc_pkg::word_type bmin_ff [3], bmin_in [3];
   aafc_pkg::word_type bmax_ff [3], bmax_in [3];
   aafc_pkg::word_type vmin_ff [3], vmin_in [3];
   aafc_pkg::word_type vmax_ff [3], vmax_in [3];
   aafc_pkg::word_type ctr_ff  [3], ctr_in  [3];
   logic signed [CW-1:0] acc_ff, acc_in;
   aafc_pkg::word_type   best_ff, best_in;
   logic [30:0]          midz_ff, midz_in;
   logic [63:0]          sq_ff, sq_in;
   logic                 ovf_ff, ovf_in;
   logic [30:0]          eye_ff, eye_in;
   logic [30:0]          mid_ff, mid_in;
   logic [30:0]          near_ff, far_ff;

   logic [aafc_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [AW-1:0]                    raddr, raddr_q_ff;
   logic [31:0]                      rd_data;
   logic                             tbl_we;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_vis_ff, rsp_vis_in;
   aafc_pkg::word_type   rsp_mpd_ff, rsp_mpd_in;
   logic [30:0]          rsp_eye_ff, rsp_eye_in;
   logic [30:0]          rsp_mid_ff, rsp_mid_in;

   logic                            mul_en;
   logic signed [MW-1:0]            mul_a, mul_b;
   logic signed [aafc_pkg::PROD_W-1:0] prod;
   aafc_pkg::word_type              prod_q;
   aafc_pkg::word_type              coef;
   aafc_pkg::word_type              comp;
   logic signed [MW-1:0]            dist_op;
   logic                            dist_big;
   aafc_pkg::word_type              res_p;
   logic [30:0]                     root_sat;

   aafc_pkg::sqrt_ctl_type  sq_ctl;
   aafc_pkg::sqrt_stat_type sq_stat;

   logic req_xfer, test_xfer;

   assign req_stall = (state_ff != aafc_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign test_xfer = req_xfer && (req_opcode == aafc_pkg::OP_TEST);
   assign tbl_we    = req_xfer && (req_opcode == aafc_pkg::OP_WRITE)
                      && (req_coef_index < AW'(aafc_pkg::TABLE_DEPTH));

   aafc_ram #(.WIDTH(32), .DEPTH(aafc_pkg::TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (req_coef_index),
      .wr_data (req_coef_value),
      .rd_addr (raddr),
      .rd_data (rd_data)
   );

   aafc_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   aafc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .ctl   (sq_ctl),
      .stat  (sq_stat)
   );

   // entries never written read as zero
   assign coef   = valid_ff[raddr_q_ff] ? aafc_pkg::word_type'(rd_data) : '0;
   assign prod_q = aafc_pkg::qsat(prod);

   always_comb begin
      case (word_ff)
         2'd0:    comp = grp_ff[0] ? bmax_ff[0] : bmin_ff[0];
         2'd1:    comp = grp_ff[1] ? bmax_ff[1] : bmin_ff[1];
         default: comp = grp_ff[2] ? bmax_ff[2] : bmin_ff[2];
      endcase
   end

   always_comb begin
      if (row_ff == 2'd2 && grp_ff[0]) begin
         dist_op = MW'(ctr_ff[2]) + $signed({2'b00, midz_ff});
      end else begin
         dist_op = MW'(ctr_ff[row_ff]);
      end
   end

   assign dist_big = (dist_op > MW'(signed'(32'sh7FFF_FFFF)))
                     || (dist_op < -MW'(signed'(32'sh7FFF_FFFF)));
   assign root_sat = ovf_ff ? aafc_pkg::DIST_MAX
                     : (sq_stat.root[31] ? aafc_pkg::DIST_MAX : sq_stat.root[30:0]);
   assign res_p    = aafc_pkg::sat_acc(acc_ff + CW'(coef));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aafc_pkg::ST_IDLE: begin
            if (test_xfer) state_in = aafc_pkg::ST_XFORM;
         end
         aafc_pkg::ST_XFORM: begin
            if (ph_ff == 2'd2 && word_ff == 2'd3 && row_ff == 2'd2 && grp_ff == 3'd7)
               state_in = aafc_pkg::ST_PLANE;
         end
         aafc_pkg::ST_PLANE: begin
            if (ph_ff == 2'd2 && word_ff == 2'd3 && grp_ff == 3'd5)
               state_in = aafc_pkg::ST_DIST;
         end
         aafc_pkg::ST_DIST: begin
            if (ph_ff == 2'd1 && row_ff == 2'd2) state_in = aafc_pkg::ST_ROOT;
         end
         aafc_pkg::ST_ROOT: begin
            if (ph_ff == 2'd1 && sq_stat.done)
               state_in = grp_ff[0] ? aafc_pkg::ST_FINISH : aafc_pkg::ST_DIST;
         end
         aafc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = aafc_pkg::ST_IDLE;
         end
         default: state_in = aafc_pkg::ST_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      raddr        = '0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      sq_ctl.start    = 1'b0;
      sq_ctl.radicand = sq_ff;
      unique case (state_ff)
         aafc_pkg::ST_XFORM: begin
            raddr = AW'({row_ff, word_ff});
            if (ph_ff == 2'd1 && word_ff != 2'd3) begin
               mul_en = 1'b1;
               mul_a  = MW'(coef);
               mul_b  = MW'(comp);
            end
         end
         aafc_pkg::ST_PLANE: begin
            raddr = AW'(aafc_pkg::PLANE_BASE) + AW'({grp_ff, word_ff});
            if (ph_ff == 2'd1 && word_ff != 2'd3) begin
               mul_en = 1'b1;
               mul_a  = MW'(coef);
               // zero normal picks the max corner
               mul_b  = coef[31] ? MW'(vmin_ff[word_ff]) : MW'(vmax_ff[word_ff]);
            end
         end
         aafc_pkg::ST_DIST: begin
            if (ph_ff == 2'd0) begin
               mul_en = 1'b1;
               mul_a  = dist_op;
               mul_b  = dist_op;
            end
         end
         aafc_pkg::ST_ROOT: begin
            sq_ctl.start = (ph_ff == 2'd0);
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      grp_in  = grp_ff;
      row_in  = row_ff;
      word_in = word_ff;
      ph_in   = ph_ff;
      bmin_in = bmin_ff;
      bmax_in = bmax_ff;
      vmin_in = vmin_ff;
      vmax_in = vmax_ff;
      ctr_in  = ctr_ff;
      acc_in  = acc_ff;
      best_in = best_ff;
      midz_in = midz_ff;
      sq_in   = sq_ff;
      ovf_in  = ovf_ff;
      eye_in  = eye_ff;
      mid_in  = mid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vis_in   = rsp_vis_ff;
      rsp_mpd_in   = rsp_mpd_ff;
      rsp_eye_in   = rsp_eye_ff;
      rsp_mid_in   = rsp_mid_ff;

      case (state_ff)
         aafc_pkg::ST_IDLE: begin
            if (test_xfer) begin
               bmin_in[0] = req_box_min_x;
               bmin_in[1] = req_box_min_y;
               bmin_in[2] = req_box_min_z;
               bmax_in[0] = req_box_max_x;
               bmax_in[1] = req_box_max_y;
               bmax_in[2] = req_box_max_z;
               grp_in  = '0;
               row_in  = '0;
               word_in = '0;
               ph_in   = '0;
               acc_in  = '0;
            end
         end
         aafc_pkg::ST_XFORM: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in   = '0;
               word_in = word_ff + 2'd1;
               if (word_ff != 2'd3) begin
                  acc_in = acc_ff + CW'(prod_q);
               end else begin
                  acc_in = '0;
                  if (grp_ff == 3'd0 || res_p < vmin_ff[row_ff]) vmin_in[row_ff] = res_p;
                  if (grp_ff == 3'd0 || res_p > vmax_ff[row_ff]) vmax_in[row_ff] = res_p;
                  row_in = (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
                  if (row_ff == 2'd2) grp_in = grp_ff + 3'd1;
               end
            end
         end
         aafc_pkg::ST_PLANE: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in   = '0;
               word_in = word_ff + 2'd1;
               if (word_ff != 2'd3) begin
                  acc_in = acc_ff + CW'(prod_q);
               end else begin
                  acc_in = '0;
                  if (grp_ff == 3'd0 || res_p < best_ff) best_in = res_p;
                  grp_in = grp_ff + 3'd1;
                  if (grp_ff == 3'd5) begin
                     for (int i = 0; i < 3; i++) begin
                        ctr_in[i] = aafc_pkg::word_type'(
                           (CW'(vmin_ff[i]) + CW'(vmax_ff[i])) >>> 1);
                     end
                     midz_in = 31'((32'(near_ff) + 32'(far_ff)) >> 1);
                     grp_in  = '0;
                     row_in  = '0;
                     sq_in   = '0;
                     ovf_in  = 1'b0;
                  end
               end
            end
         end
         aafc_pkg::ST_DIST: begin
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
               if (dist_big) ovf_in = 1'b1;
            end else begin
               ph_in  = '0;
               sq_in  = sq_ff + prod[63:0];
               row_in = row_ff + 2'd1;
            end
         end
         aafc_pkg::ST_ROOT: begin
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else if (sq_stat.done) begin
               ph_in  = '0;
               row_in = '0;
               sq_in  = '0;
               ovf_in = 1'b0;
               if (grp_ff[0]) begin
                  mid_in = root_sat;
               end else begin
                  eye_in = root_sat;
                  grp_in = 3'd1;
               end
            end
         end
         aafc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_vis_in   = !best_ff[31];
               rsp_mpd_in   = best_ff;
               rsp_eye_in   = eye_ff;
               rsp_mid_in   = mid_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aafc_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         near_ff      <= aafc_pkg::NEAR_RESET;
         far_ff       <= aafc_pkg::FAR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tbl_we) valid_ff[req_coef_index] <= 1'b1;
         if (csr_write_enable) begin
            if (csr_index == aafc_pkg::CSR_NEAR) near_ff <= csr_write_data;
            else                                  far_ff  <= csr_write_data;
         end
      end
      raddr_q_ff <= raddr;
      grp_ff  <= grp_in;
      row_ff  <= row_in;
      word_ff <= word_in;
      ph_ff   <= ph_in;
      bmin_ff <= bmin_in;
      bmax_ff <= bmax_in;
      vmin_ff <= vmin_in;
      vmax_ff <= vmax_in;
      ctr_ff  <= ctr_in;
      acc_ff  <= acc_in;
      best_ff <= best_in;
      midz_ff <= midz_in;
      sq_ff   <= sq_in;
      ovf_ff  <= ovf_in;
      eye_ff  <= eye_in;
      mid_ff  <= mid_in;
      rsp_vis_ff <= rsp_vis_in;
      rsp_mpd_ff <= rsp_mpd_in;
      rsp_eye_ff <= rsp_eye_in;
      rsp_mid_ff <= rsp_mid_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_visible              = rsp_vis_ff;
   assign rsp_min_plane_distance   = rsp_mpd_ff;
   assign rsp_eye_distance         = rsp_eye_ff;
   assign rsp_frustum_mid_distance = rsp_mid_ff;

   `AAFC_ASSERT_NEXT(a_no_dup_result,
      rsp_valid_ff && !rsp_stall && state_ff != aafc_pkg::ST_FINISH, !rsp_valid_ff,
      "result transfer repeated")
   `AAFC_ASSERT_IMP(a_visible_sign, rsp_valid_ff,
      rsp_visible == !rsp_min_plane_distance[31], "visible flag disagrees with distance")
   `AAFC_ASSERT_NEXT(a_test_starts, test_xfer, state_ff == aafc_pkg::ST_XFORM,
      "accepted test did not start transform")
   `AAFC_ASSERT_IMP(a_root_owned, state_ff != aafc_pkg::ST_ROOT, !sq_stat.busy,
      "square root unit busy outside root phase")

endmodule
